// ===== rtl/core/pbal_pkg.sv =====
// ----------------------------------------------------------------------------
// pbal_pkg
// Shared types and codes for the power-of-two block allocator.
// ----------------------------------------------------------------------------
package pbal_pkg;

    localparam int CLS_W = 5;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_MEM    = 2'd1,
        STS_TOO_LARGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_SPLIT,
        S_FREE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              is_free;
        logic              too_large;
        logic [CLS_W-1:0]  cls;
        logic [15:0]       free_block;
    } cmd_t;

endpackage

// ===== rtl/core/pbal_front.sv =====
// ----------------------------------------------------------------------------
// pbal_front
// Accepts requests, picks the size class, and queues commands for the back.
// ----------------------------------------------------------------------------
module pbal_front #(
    parameter int NUM_CLASSES     = 12,
    parameter int MIN_BLOCK_BYTES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           req_type,
    input  logic [15:0]    req_size,
    input  logic [15:0]    free_block,
    output logic           q_valid,
    input  logic           q_pop,
    output pbal_pkg::cmd_t q_cmd
);
    import pbal_pkg::*;

    localparam logic [63:0] MAX_NEED = 64'(MIN_BLOCK_BYTES) << (NUM_CLASSES - 1);

    logic [15:0]      padded;
    logic [16:0]      need;
    logic [CLS_W-1:0] cls;
    cmd_t             cmd;
    logic             push;

    cmd_t        q_mem_reg [2];
    logic        wptr_reg;
    logic        wptr_next;
    logic        rptr_reg;
    logic        rptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        padded = (req_size < 16'd24) ? 16'd24 : req_size;
        need   = {1'b0, padded} + 17'd8;
        cls    = CLS_W'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 2; c >= 0; c--)
        begin
            if (64'(need) <= (64'(MIN_BLOCK_BYTES) << c))
                cls = CLS_W'(c);
        end
        cmd.is_free    = req_type;
        cmd.too_large  = ~req_type && (64'(need) > MAX_NEED);
        cmd.cls        = cls;
        cmd.free_block = free_block;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ (q_pop && q_valid);
        count_next = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wptr_reg] <= cmd;
    end

endmodule

// ===== rtl/core/pbal_back.sv =====
// ----------------------------------------------------------------------------
// pbal_back
// Executes queued commands: list pops, bump refills, splits, frees.
// ----------------------------------------------------------------------------
module pbal_back #(
    parameter int NUM_CLASSES   = 12,
    parameter int HEAP_GRANULES = 65536
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [5:0]     cfg_wdata,
    input  logic           q_valid,
    output logic           q_pop,
    input  pbal_pkg::cmd_t q_cmd,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status,
    output logic [15:0]    block_granule,
    output logic [3:0]     block_class
);
    import pbal_pkg::*;

    localparam int GW  = $clog2(HEAP_GRANULES);
    localparam int CIW = $clog2(NUM_CLASSES);
    localparam int CAP = HEAP_GRANULES >> (NUM_CLASSES - 1);
    localparam logic [5:0] CAP6 = (CAP > 63) ? 6'd63 : 6'(CAP);

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [GW-1:0]   g_reg, g_next;
    logic [CIW-1:0]  j_reg, j_next;
    logic [5:0]      limit_reg;
    logic [5:0]      used_reg, used_next;
    logic [GW:0]     head_reg [NUM_CLASSES];
    logic [GW:0]     head_next [NUM_CLASSES];

    status_t         res_sts;
    logic [15:0]     res_gran;
    logic [CIW-1:0]  res_cls;
    status_t         rs_reg, rs_next;
    logic [15:0]     rg_reg, rg_next;
    logic [CIW-1:0]  rc_reg, rc_next;

    logic            ov_reg, ov_next;
    logic [1:0]      st_out_reg, st_out_next;
    logic [15:0]     gr_out_reg, gr_out_next;
    logic [3:0]      cl_out_reg, cl_out_next;

    logic [GW:0]     link_mem [HEAP_GRANULES];
    logic [CIW-1:0]  tag_mem [HEAP_GRANULES];
    logic            link_we, link_re, tag_we, tag_re;
    logic [GW-1:0]   link_waddr, link_raddr, tag_waddr, tag_raddr;
    logic [GW:0]     link_wdata, link_rdata;
    logic [CIW-1:0]  tag_wdata, tag_rdata;

    logic            found;
    logic [CIW-1:0]  kidx;
    logic [CIW-1:0]  cls_w;
    logic [5:0]      limit_eff;
    logic [GW-1:0]   fb_g;
    logic            fb_oor;
    logic [GW-1:0]   upper;

    always_comb
    begin
        cls_w     = cmd_reg.cls[CIW-1:0];
        limit_eff = (limit_reg > CAP6) ? CAP6 : limit_reg;
        fb_g      = GW'(cmd_reg.free_block);
        fb_oor    = (32'(cmd_reg.free_block) >= HEAP_GRANULES);
        upper     = g_reg + GW'(32'(1) << (j_reg - 1'b1));
        found     = 1'b0;
        kidx      = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (head_reg[i][GW] && (CIW'(i) >= cls_w))
            begin
                found = 1'b1;
                kidx  = CIW'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        g_next      = g_reg;
        j_next      = j_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        rs_next     = rs_reg;
        rg_next     = rg_reg;
        rc_next     = rc_reg;
        ov_next     = ov_reg && out_stall;
        st_out_next = st_out_reg;
        gr_out_next = gr_out_reg;
        cl_out_next = cl_out_reg;
        q_pop       = 1'b0;
        link_we     = 1'b0;
        link_re     = 1'b0;
        tag_we      = 1'b0;
        tag_re      = 1'b0;
        link_waddr  = upper;
        link_wdata  = '0;
        link_raddr  = g_reg;
        tag_waddr   = upper;
        tag_wdata   = '0;
        tag_raddr   = fb_g;
        res_sts     = STS_OK;
        res_gran    = '0;
        res_cls     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (cmd_reg.too_large)
                begin
                    rs_next    = STS_TOO_LARGE;
                    rg_next    = '0;
                    rc_next    = '0;
                    state_next = S_EMIT;
                end
                else if (cmd_reg.is_free)
                begin
                    if (fb_oor)
                    begin
                        rs_next    = STS_OK;
                        rg_next    = cmd_reg.free_block;
                        rc_next    = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        tag_re     = 1'b1;
                        state_next = S_FREE;
                    end
                end
                else if (found)
                begin
                    g_next     = head_reg[kidx][GW-1:0];
                    j_next     = kidx;
                    link_re    = 1'b1;
                    link_raddr = head_reg[kidx][GW-1:0];
                    state_next = S_POP;
                end
                else if (used_reg >= limit_eff)
                begin
                    rs_next    = STS_NO_MEM;
                    rg_next    = '0;
                    rc_next    = cls_w;
                    state_next = S_EMIT;
                end
                else
                begin
                    g_next     = GW'(32'(used_reg) << (NUM_CLASSES - 1));
                    used_next  = used_reg + 6'd1;
                    j_next     = CIW'(NUM_CLASSES - 1);
                    state_next = S_SPLIT;
                end
            end
            S_POP:
            begin
                head_next[j_reg] = link_rdata;
                state_next       = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (j_reg > cls_w)
                begin
                    tag_we                  = 1'b1;
                    tag_waddr               = upper;
                    tag_wdata               = j_reg - 1'b1;
                    link_we                 = 1'b1;
                    link_waddr              = upper;
                    link_wdata              = head_reg[j_reg - 1'b1];
                    head_next[j_reg - 1'b1] = {1'b1, upper};
                    j_next                  = j_reg - 1'b1;
                end
                else
                begin
                    tag_we     = 1'b1;
                    tag_waddr  = g_reg;
                    tag_wdata  = cls_w;
                    rs_next    = STS_OK;
                    rg_next    = 16'(g_reg);
                    rc_next    = cls_w;
                    state_next = S_EMIT;
                end
            end
            S_FREE:
            begin
                rs_next = STS_OK;
                rg_next = cmd_reg.free_block;
                if (32'(tag_rdata) >= NUM_CLASSES)
                    rc_next = '0;
                else
                begin
                    link_we              = 1'b1;
                    link_waddr           = fb_g;
                    link_wdata           = head_reg[tag_rdata];
                    head_next[tag_rdata] = {1'b1, fb_g};
                    rc_next              = tag_rdata;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_sts  = rs_reg;
                res_gran = rg_reg;
                res_cls  = rc_reg;
                if (!ov_reg || !out_stall)
                begin
                    ov_next     = 1'b1;
                    st_out_next = res_sts;
                    gr_out_next = res_gran;
                    cl_out_next = 4'(res_cls);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= 6'd0;
            limit_reg <= 6'd32;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
                head_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            head_reg  <= head_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        g_reg      <= g_next;
        j_reg      <= j_next;
        rs_reg     <= rs_next;
        rg_reg     <= rg_next;
        rc_reg     <= rc_next;
        st_out_reg <= st_out_next;
        gr_out_reg <= gr_out_next;
        cl_out_reg <= cl_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (link_re)
            link_rdata <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_waddr] <= tag_wdata;
        if (tag_re)
            tag_rdata <= tag_mem[tag_raddr];
    end

    assign out_valid     = ov_reg;
    assign status        = st_out_reg;
    assign block_granule = gr_out_reg;
    assign block_class   = cl_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= CAP6)
        else $error("bump counter past heap capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |-> j_reg >= cls_w)
        else $error("split level below requested class");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> $past(state_reg) == S_START)
        else $error("pop without list lookup");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(link_we && link_re))
        else $error("link memory read and write in one cycle");

endmodule

// ===== rtl/core/power_of_two_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_unit
// Buddy-style allocator over a granule heap with per-class LIFO free lists.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall: req_type 0 allocates req_size bytes,
// 1 frees the block at free_block. Each request yields exactly one result
// beat on out_valid/out_stall: status, block_granule, block_class.
// The front classifies a request in its accept cycle and holds it in a
// two-entry queue; the back executes one command at a time.
// With the back idle, a free of an in-range block reads its tag and, if the
// tag names a class, pushes the block onto that list. An allocate pops the
// smallest nonempty list of its class or above, or if none takes a fresh top
// block from the bump counter, then splits down (up to NUM_CLASSES-1
// levels), pushing each upper half onto its list; the list memory takes one
// push per cycle. Too-large and out-of-memory results go straight to emit.
// The back starts the next queued command only after loading a result.
// cfg_we writes top_block_limit; write it only while the block is idle.
// Reset empties all free lists, clears the bump counter and sets the limit
// to 32. Link and tag memories are not cleared. When the receiver stalls,
// the result register holds, the back waits, and the queue fills until
// in_stall rises.
// ----------------------------------------------------------------------------
module power_of_two_block_allocator_unit #(
    parameter int NUM_CLASSES     = 12,
    parameter int MIN_BLOCK_BYTES = 32,
    parameter int HEAP_GRANULES   = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] req_size,
    input  logic [15:0] free_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] block_granule,
    output logic [3:0]  block_class
);
    import pbal_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    pbal_front #(
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .req_size   (req_size),
        .free_block (free_block),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd)
    );

    pbal_back #(
        .NUM_CLASSES   (NUM_CLASSES),
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .block_granule (block_granule),
        .block_class   (block_class)
    );

endmodule
